/* hw/rtl/aecu_pkg.sv */
// Shared types and constants for the array element address calculator.
`timescale 1ns / 1ps
`default_nettype none
package aecu_pkg;

    localparam int MAX_ARRAYS_DEF = 128;
    localparam int MAX_DIMS_DEF   = 16;

    localparam int OP_W    = 2;
    localparam int ID_W    = 7;
    localparam int BASE_W  = 31;
    localparam int ESIZE_W = 16;
    localparam int DCNT_W  = 5;
    localparam int WORD_W  = 32;

    // header entry: {base, element size, dimension count}
    localparam int HDR_W = BASE_W + ESIZE_W + DCNT_W;
    // dimension entry: {lower bound, extent}
    localparam int DIM_W = 2 * WORD_W;

    // wide enough for any table slot number over the parameter range
    localparam int SLOT_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_HEADER = 2'd0,
        OP_BOUNDS = 2'd1,
        OP_INDEX  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ID_W-1:0]    array_id;
        logic [BASE_W-1:0]  base_addr;
        logic [ESIZE_W-1:0] elem_size;
        logic [DCNT_W-1:0]  dim_count;
        logic [DCNT_W-1:0]  dim_pos;
        logic signed [WORD_W-1:0] lower_bound;
        logic signed [WORD_W-1:0] upper_bound;
        logic signed [WORD_W-1:0] index_value;
    } t_in_beat;

    typedef struct packed {
        logic [ID_W-1:0]          ref_array;
        logic signed [WORD_W-1:0] address;
    } t_out_beat;

endpackage
`default_nettype wire

/* hw/rtl/aecu_in_if.sv */
// Input channel: valid/ready handshake carrying one command beat.
`timescale 1ns / 1ps
`default_nettype none
interface aecu_in_if;
    logic               valid;
    logic               ready;
    aecu_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/aecu_out_if.sv */
// Output channel: valid/ready handshake carrying one address beat.
`timescale 1ns / 1ps
`default_nettype none
interface aecu_out_if;
    logic                valid;
    logic                ready;
    aecu_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/aecu_ram.sv */
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module aecu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/array_element_address_calc_unit.sv */
// Top level: row-major element address calculator over a descriptor table.
//
//  port   | dir | beat                | accepted when
//  -------+-----+---------------------+---------------------------
//  i_in   | in  | t_in_beat (command) | i_in.valid & i_in.ready
//  o_out  | out | t_out_beat (result) | o_out.valid & o_out.ready
//
// Header and bounds commands are a single table write.
// An index beat is a table read, then a multiply-accumulate into the
// offset register; on the last dimension an address step forms
// base + size * offset into the output register (waits there while it is full).
// The output register holds a result while the next beat is taken.
// Reset (sync, active low) clears control and the offset; tables are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module array_element_address_calc_unit #(
    parameter int MAX_ARRAYS = aecu_pkg::MAX_ARRAYS_DEF,
    parameter int MAX_DIMS   = aecu_pkg::MAX_DIMS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    aecu_in_if.sink    i_in,
    aecu_out_if.source o_out
);

    localparam int DIM_DEPTH = MAX_ARRAYS * MAX_DIMS;
    localparam int HDR_AW    = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
    localparam int DIM_AW    = (DIM_DEPTH > 1) ? $clog2(DIM_DEPTH) : 1;
    localparam int WW        = aecu_pkg::WORD_W;
    localparam int SW        = aecu_pkg::SLOT_W;
    localparam int DW        = aecu_pkg::DCNT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MAC  = 3'b010,
        S_ADDR = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [aecu_pkg::ID_W-1:0] r_id;
    logic [DW-1:0]             r_pos;
    logic [WW-1:0]             r_idx;
    logic [WW-1:0]             r_acc, n_acc;
    logic                      r_out_valid;
    aecu_pkg::t_out_beat       r_out_data;

    aecu_pkg::t_in_beat in_beat;
    logic               accept, id_ok, pos_ok;
    logic               hdr_en, hdr_we, dim_en, dim_we;
    logic [SW-1:0]      slot;
    logic [DW-1:0]      dcnt_clamped;
    logic [aecu_pkg::HDR_W-1:0] hdr_wdata, hdr_rdata;
    logic [aecu_pkg::DIM_W-1:0] dim_wdata, dim_rdata;

    logic [aecu_pkg::BASE_W-1:0]  rd_base;
    logic [aecu_pkg::ESIZE_W-1:0] rd_size;
    logic [DW-1:0]                rd_dims;
    logic [WW-1:0]                rd_lower, rd_extent, term;
    logic                         out_free;

    assign in_beat  = i_in.data;
    assign i_in.ready = (r_state == S_IDLE);
    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign id_ok  = SW'(in_beat.array_id) < SW'(MAX_ARRAYS);
    assign pos_ok = (in_beat.dim_pos != '0) && (SW'(in_beat.dim_pos) <= SW'(MAX_DIMS));
    assign slot   = SW'(in_beat.array_id) * SW'(MAX_DIMS) + SW'(in_beat.dim_pos) - SW'(1);

    always_comb begin
        if (in_beat.dim_count == '0) begin
            dcnt_clamped = DW'(1);
        end else if (SW'(in_beat.dim_count) > SW'(MAX_DIMS)) begin
            dcnt_clamped = DW'(MAX_DIMS);
        end else begin
            dcnt_clamped = in_beat.dim_count;
        end
    end

    // table port control: header written by op 0, read by index beats;
    // dimension entry written by op 1, read by index beats
    always_comb begin
        hdr_en = 1'b0;
        hdr_we = 1'b0;
        dim_en = 1'b0;
        dim_we = 1'b0;
        if (accept && id_ok) begin
            unique case (aecu_pkg::t_op'(in_beat.op))
                aecu_pkg::OP_HEADER: begin
                    hdr_en = 1'b1;
                    hdr_we = 1'b1;
                end
                aecu_pkg::OP_BOUNDS: begin
                    dim_en = pos_ok;
                    dim_we = pos_ok;
                end
                aecu_pkg::OP_INDEX: begin
                    hdr_en = pos_ok;
                    dim_en = pos_ok;
                end
                default: begin
                end
            endcase
        end
    end

    assign hdr_wdata = {in_beat.base_addr, in_beat.elem_size, dcnt_clamped};
    assign dim_wdata = {in_beat.lower_bound,
                        in_beat.upper_bound - in_beat.lower_bound + WW'(1)};

    aecu_ram #(
        .WIDTH (aecu_pkg::HDR_W),
        .DEPTH (MAX_ARRAYS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_en    (hdr_en),
        .i_we    (hdr_we),
        .i_addr  (HDR_AW'(in_beat.array_id)),
        .i_wdata (hdr_wdata),
        .o_rdata (hdr_rdata)
    );

    aecu_ram #(
        .WIDTH (aecu_pkg::DIM_W),
        .DEPTH (DIM_DEPTH)
    ) u_dim_ram (
        .i_clk   (i_clk),
        .i_en    (dim_en),
        .i_we    (dim_we),
        .i_addr  (slot[DIM_AW-1:0]),
        .i_wdata (dim_wdata),
        .o_rdata (dim_rdata)
    );

    assign {rd_base, rd_size, rd_dims} = hdr_rdata;
    assign {rd_lower, rd_extent}       = dim_rdata;
    assign term = r_idx - rd_lower;

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        unique case (r_state)
            S_IDLE: begin
                if (accept && id_ok && pos_ok
                        && aecu_pkg::t_op'(in_beat.op) == aecu_pkg::OP_INDEX) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                // Horner step; first dimension restarts the offset
                if (r_pos == DW'(1)) begin
                    n_acc = term;
                end else begin
                    n_acc = r_acc * rd_extent + term;
                end
                n_state = (r_pos == rd_dims) ? S_ADDR : S_IDLE;
            end
            S_ADDR: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            if (r_state == S_ADDR && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id  <= in_beat.array_id;
            r_pos <= in_beat.dim_pos;
            r_idx <= in_beat.index_value;
        end
        if (r_state == S_ADDR && out_free) begin
            r_out_data.ref_array <= r_id;
            r_out_data.address   <= WW'(rd_base) + WW'(rd_size) * r_acc;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

`ifndef SYNTHESIS
    a_index_goes_to_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && id_ok && pos_ok
            && in_beat.op == aecu_pkg::OP_INDEX) |=> (r_state == S_MAC))
        else $error("index beat did not start a table read");

    a_mac_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |=> (r_state == S_IDLE || r_state == S_ADDR))
        else $error("accumulate step left to a bad state");

    a_result_from_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_ADDR))
        else $error("result loaded outside the address step");

    a_addr_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR && r_out_valid && !o_out.ready) |=> (r_state == S_ADDR))
        else $error("address step overran a full output register");
`endif

endmodule
`default_nettype wire
